>>> rtl/fixup_record_boundary_parser_unit_defines.svh
// Assertion macros shared by the verification side of the fixup record parser.
// Needs signals named aclk and aresetn in the including scope.
`ifndef FIXUP_RECORD_BOUNDARY_PARSER_UNIT_DEFINES_SVH
`define FIXUP_RECORD_BOUNDARY_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FRBP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define FRBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/frbp_pkg.sv
// Types, constants and helpers for the fixup record boundary parser.
// No dependencies.
package frbp_pkg;

    localparam int OUT_W   = 20;
    localparam int LEN_W   = 10;
    localparam int FIFO_AW = 2;

    localparam logic [7:0] SRC_BAD_MASK = 8'hC0;
    localparam logic [7:0] SRC_LIST     = 8'h20;
    localparam logic [7:0] FLG_OBJ16    = 8'h40;
    localparam logic [7:0] FLG_OFF32    = 8'h10;
    localparam logic [3:0] SRC_SEL_ONLY = 4'h2;
    localparam logic [7:0] FLG_TGT_MASK = 8'h03;

    localparam logic [LEN_W-1:0] BIR_MAX = '1;

    typedef enum logic [2:0] {
        ST_END      = 3'd0,
        ST_ZERO_SRC = 3'd1,
        ST_BAD_SRC  = 3'd2,
        ST_BAD_TGT  = 3'd3,
        ST_TRUNC    = 3'd4
    } frbp_status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } frbp_in_t;

    typedef struct packed {
        logic             result_kind;
        logic [OUT_W-1:0] offset_value;
        logic [2:0]       stop_status;
        logic             final_mark;
    } frbp_out_t;

    typedef struct packed {
        logic      rec_vld;
        logic      fin_vld;
        frbp_out_t rec;
        frbp_out_t fin;
    } frbp_push_t;

    function automatic logic [LEN_W-1:0] rec_len(input logic [7:0] src,
                                                 input logic [7:0] flg,
                                                 input logic [7:0] cnt);
        logic [LEN_W-1:0] len;
        len = ((src & SRC_LIST) != 8'h00) ? LEN_W'(3) : LEN_W'(4);
        len = len + (((flg & FLG_OBJ16) != 8'h00) ? LEN_W'(2) : LEN_W'(1));
        if (src[3:0] != SRC_SEL_ONLY) begin
            len = len + (((flg & FLG_OFF32) != 8'h00) ? LEN_W'(4) : LEN_W'(2));
        end
        if ((src & SRC_LIST) != 8'h00) begin
            len = len + {1'b0, cnt, 1'b0};
        end
        return len;
    endfunction

endpackage

>>> rtl/frbp_core.sv
// Record parsing state and per-byte decode for the fixup record parser.
// Depends on frbp_pkg.
module frbp_core #(
    parameter int OFFSET_BITS = 20
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_vld,
    input  frbp_pkg::frbp_in_t  in_data,
    output frbp_pkg::frbp_push_t push
);
    import frbp_pkg::*;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
    localparam logic [OFFSET_BITS-1:0] OFF_ONE = {{(OFFSET_BITS-1){1'b0}}, 1'b1};

    function automatic logic [OFFSET_BITS-1:0] sat_add(input logic [OFFSET_BITS-1:0] a,
                                                       input logic [OFFSET_BITS-1:0] b);
        logic [OFFSET_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[OFFSET_BITS] ? OFF_MAX : s[OFFSET_BITS-1:0];
    endfunction

    function automatic logic [OFFSET_BITS-1:0] ext_len(input logic [LEN_W-1:0] x);
        return {{(OFFSET_BITS-LEN_W){1'b0}}, x};
    endfunction

    function automatic logic [OUT_W-1:0] to_out(input logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS+OUT_W-1:0] w;
        w = {{OUT_W{1'b0}}, v};
        return w[OUT_W-1:0];
    endfunction

    logic [OFFSET_BITS-1:0] pos_reg,  pos_next;
    logic [OFFSET_BITS-1:0] rs_reg,   rs_next;
    logic [OFFSET_BITS-1:0] plen_reg, plen_next;
    logic [LEN_W-1:0]       bir_reg,  bir_next;
    logic [LEN_W-1:0]       need_reg, need_next;
    logic                   known_reg, known_next;
    logic [7:0]             src_reg,  src_next;
    logic [7:0]             flg_reg,  flg_next;
    logic                   stop_reg, stop_next;
    frbp_status_t           status_reg, status_next;

    logic                   stop_hit;
    frbp_status_t           stop_code;
    logic [LEN_W-1:0]       stop_ext;
    logic                   src_is_list;

    assign src_is_list = (src_reg & SRC_LIST) != 8'h00;

    always_comb begin
        pos_next    = pos_reg;
        rs_next     = rs_reg;
        plen_next   = plen_reg;
        bir_next    = bir_reg;
        need_next   = need_reg;
        known_next  = known_reg;
        src_next    = src_reg;
        flg_next    = flg_reg;
        stop_next   = stop_reg;
        status_next = status_reg;
        stop_hit    = 1'b0;
        stop_code   = ST_END;
        stop_ext    = '0;
        push        = '0;

        if (in_vld) begin
            if (!stop_reg) begin
                if (bir_reg == '0) begin
                    rs_next = pos_reg;
                end
                pos_next = sat_add(pos_reg, OFF_ONE);
                if (bir_reg != BIR_MAX) begin
                    bir_next = bir_reg + LEN_W'(1);
                end

                priority if (bir_reg == LEN_W'(0)) begin
                    src_next = in_data.data_byte;
                    if (in_data.data_byte == 8'h00) begin
                        stop_hit  = 1'b1;
                        stop_code = ST_ZERO_SRC;
                        stop_ext  = LEN_W'(1);
                    end
                end else if (bir_reg == LEN_W'(1)) begin
                    flg_next = in_data.data_byte;
                    if ((src_reg & SRC_BAD_MASK) != 8'h00) begin
                        stop_hit  = 1'b1;
                        stop_code = ST_BAD_SRC;
                        stop_ext  = LEN_W'(2);
                    end else if (!src_is_list) begin
                        if ((in_data.data_byte & FLG_TGT_MASK) != 8'h00) begin
                            stop_hit  = 1'b1;
                            stop_code = ST_BAD_TGT;
                            stop_ext  = LEN_W'(4);
                        end else begin
                            need_next  = rec_len(src_reg, in_data.data_byte, 8'd1);
                            known_next = 1'b1;
                        end
                    end
                end else if (bir_reg == LEN_W'(2) && src_is_list && !known_reg) begin
                    if ((flg_reg & FLG_TGT_MASK) != 8'h00) begin
                        stop_hit  = 1'b1;
                        stop_code = ST_BAD_TGT;
                        stop_ext  = LEN_W'(3);
                    end else begin
                        need_next  = rec_len(src_reg, flg_reg, in_data.data_byte);
                        known_next = 1'b1;
                    end
                end else begin
                    // payload byte of a record
                end

                if (stop_hit) begin
                    stop_next   = 1'b1;
                    status_next = stop_code;
                    plen_next   = sat_add(rs_next, ext_len(stop_ext));
                end

                if (!stop_next && known_next && bir_next == need_next) begin
                    push.rec_vld              = 1'b1;
                    push.rec.result_kind      = 1'b0;
                    push.rec.offset_value     = to_out(rs_next);
                    push.rec.stop_status      = ST_END;
                    push.rec.final_mark       = 1'b0;
                    bir_next                  = '0;
                    need_next                 = '0;
                    known_next                = 1'b0;
                end

                if (in_data.last_byte && !stop_next) begin
                    if (bir_next == '0) begin
                        status_next = ST_END;
                        plen_next   = pos_next;
                    end else begin
                        status_next = ST_TRUNC;
                        plen_next   = sat_add(rs_next,
                                              ext_len(known_next ? need_next : bir_next));
                    end
                end
            end

            if (in_data.last_byte) begin
                push.fin_vld          = 1'b1;
                push.fin.result_kind  = 1'b1;
                push.fin.offset_value = to_out(plen_next);
                push.fin.stop_status  = status_next;
                push.fin.final_mark   = 1'b1;
                pos_next    = '0;
                rs_next     = '0;
                plen_next   = '0;
                bir_next    = '0;
                need_next   = '0;
                known_next  = 1'b0;
                src_next    = '0;
                flg_next    = '0;
                stop_next   = 1'b0;
                status_next = ST_END;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            rs_reg     <= '0;
            plen_reg   <= '0;
            bir_reg    <= '0;
            need_reg   <= '0;
            known_reg  <= 1'b0;
            src_reg    <= '0;
            flg_reg    <= '0;
            stop_reg   <= 1'b0;
            status_reg <= ST_END;
        end else begin
            pos_reg    <= pos_next;
            rs_reg     <= rs_next;
            plen_reg   <= plen_next;
            bir_reg    <= bir_next;
            need_reg   <= need_next;
            known_reg  <= known_next;
            src_reg    <= src_next;
            flg_reg    <= flg_next;
            stop_reg   <= stop_next;
            status_reg <= status_next;
        end
    end

endmodule

>>> rtl/frbp_ofifo.sv
// Four-word result queue taking up to two words per cycle, one out per cycle while m_ready is high.
// Depends on frbp_pkg.
module frbp_ofifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  frbp_pkg::frbp_push_t push,
    output logic                 room,
    output logic                 m_valid,
    input  logic                 m_ready,
    output frbp_pkg::frbp_out_t  m_data
);
    import frbp_pkg::*;

    localparam int DEPTH = 1 << FIFO_AW;

    frbp_out_t          mem [DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg,  count_next;
    logic [FIFO_AW-1:0] wr_ptr_p1;
    logic [1:0]         n_push;
    logic               pop;
    frbp_out_t          first_word;

    assign m_valid    = count_reg != '0;
    assign m_data     = mem[rd_ptr_reg];
    assign pop        = m_valid && m_ready;
    assign room       = count_reg <= (FIFO_AW + 1)'(DEPTH - 2);
    assign n_push     = {1'b0, push.rec_vld} + {1'b0, push.fin_vld};
    assign wr_ptr_p1  = wr_ptr_reg + FIFO_AW'(1);
    assign first_word = push.rec_vld ? push.rec : push.fin;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(n_push);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + (FIFO_AW + 1)'(n_push) - (FIFO_AW + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.rec_vld || push.fin_vld) begin
            mem[wr_ptr_reg] <= first_word;
        end
        if (push.rec_vld && push.fin_vld) begin
            mem[wr_ptr_p1] <= push.fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/fixup_record_boundary_parser_unit.sv
// Fixup record boundary parser: walks one page's fixup record area a byte
// per word and reports each record's start offset, then a final word with
// the parsed length and stop status on the byte marked last. It takes one
// byte per cycle while the result queue has room. A byte is held in an
// input register and decoded out of it once the queue has room; its words
// are then written into a four-word result queue, from which they are
// offered. A byte that ends both a record and the page gives two words;
// the queue drains one word per cycle while m_ready is high and intake
// holds while fewer than two slots are free.
// Depends on frbp_pkg, frbp_core and frbp_ofifo.
module fixup_record_boundary_parser_unit #(
    parameter int OFFSET_BITS = 20
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  frbp_pkg::frbp_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output frbp_pkg::frbp_out_t m_data
);
    import frbp_pkg::*;

    logic       stage_vld_reg, stage_vld_next;
    frbp_in_t   stage_reg;
    logic       room;
    logic       advance;
    frbp_push_t push;

    assign advance = stage_vld_reg && room;
    assign s_ready = !stage_vld_reg || room;

    always_comb begin
        stage_vld_next = stage_vld_reg;
        if (s_valid && s_ready) begin
            stage_vld_next = 1'b1;
        end else if (advance) begin
            stage_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            stage_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_vld_reg <= 1'b0;
        end else begin
            stage_vld_reg <= stage_vld_next;
        end
    end

    frbp_core #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_vld  (advance),
        .in_data (stage_reg),
        .push    (push)
    );

    frbp_ofifo u_ofifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> rtl/frbp_chk.sv
// Port-level checks for the fixup record parser, bound to the top level.
// Depends on frbp_pkg and fixup_record_boundary_parser_unit_defines.svh.
`include "fixup_record_boundary_parser_unit_defines.svh"

module frbp_chk (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input frbp_pkg::frbp_in_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input frbp_pkg::frbp_out_t m_data
);
    import frbp_pkg::*;

    logic rec_word;
    logic fin_word;
    logic rec_clean;
    logic in_stall;
    logic out_stall;

    assign rec_word  = m_valid && !m_data.final_mark;
    assign fin_word  = m_valid && m_data.final_mark;
    assign rec_clean = !m_data.result_kind && m_data.stop_status == 3'(ST_END);
    assign in_stall  = s_valid && !s_ready;
    assign out_stall = m_valid && !m_ready;

    `FRBP_ASSERT_NOW(a_rec_word_clean, rec_word, rec_clean, "start word has final fields")
    `FRBP_ASSERT_NOW(a_fin_kind, fin_word, m_data.result_kind, "final word not a length")
    `FRBP_ASSERT_NOW(a_status_range, m_valid, m_data.stop_status <= ST_TRUNC, "bad stop status")
    `FRBP_ASSERT_NEXT(a_out_hold, out_stall, m_valid && $stable(m_data), "stalled word changed")
    `FRBP_ASSERT_NEXT(a_in_hold, in_stall, s_valid && $stable(s_data), "stalled input changed")

endmodule

bind fixup_record_boundary_parser_unit frbp_chk u_frbp_chk (.*);

>>> test/tb_fixup_record_boundary_parser_unit.sv
// Self-checking testbench for fixup_record_boundary_parser_unit: drives pages of
// fixup record bytes, predicts record start and final words, and checks each one.
// Depends on frbp_pkg and the RTL of the parser.
module tb_fixup_record_boundary_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import frbp_pkg::*;

    localparam int          OFFSET_BITS = 20;
    localparam logic [31:0] OFF_MAX     = (32'd1 << OFFSET_BITS) - 32'd1;
    localparam logic        KIND_START  = 1'b0;
    localparam logic        KIND_FINAL  = 1'b1;
    localparam int          PRINT_LIMIT = 100;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    frbp_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    frbp_out_t m_data;

    fixup_record_boundary_parser_unit #(
        .OFFSET_BITS(OFFSET_BITS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // parser state mirror
    logic [31:0]  page_pos;
    logic [31:0]  rec_start;
    logic [31:0]  end_len;
    logic [9:0]   rec_bytes;
    logic [9:0]   need_len;
    logic         len_known;
    logic         halted;
    logic [7:0]   src_b;
    logic [7:0]   flg_b;
    frbp_status_t end_status;

    frbp_out_t expected_words[$];
    logic [7:0] page_bytes[$];
    int        mismatch_count;
    int        bytes_sent;
    int        hold_cycles;
    bit        sender_gaps;
    bit        receiver_gaps;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #80_000_000;
        $display("fixup_record_boundary_parser_unit: mismatch");
        $finish;
    end

    function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, OFF_MAX}) ? OFF_MAX : s[31:0];
    endfunction

    function automatic logic [9:0] record_bytes(input logic [7:0] src, input logic [7:0] flg,
                                                input logic [7:0] cnt);
        logic [9:0] len;
        len = ((src & SRC_LIST) != 0) ? 10'd3 : 10'd4;
        len = len + (((flg & FLG_OBJ16) != 0) ? 10'd2 : 10'd1);
        if (src[3:0] != SRC_SEL_ONLY)
            len = len + (((flg & FLG_OFF32) != 0) ? 10'd4 : 10'd2);
        if ((src & SRC_LIST) != 0)
            len = len + {1'b0, cnt, 1'b0};
        return len;
    endfunction

    function automatic void clear_parse_state();
        page_pos   = '0;
        rec_start  = '0;
        end_len    = '0;
        rec_bytes  = '0;
        need_len   = '0;
        len_known  = 1'b0;
        halted     = 1'b0;
        src_b      = '0;
        flg_b      = '0;
        end_status = ST_END;
    endfunction

    function automatic void halt_parse(input frbp_status_t st, input logic [31:0] extra);
        halted     = 1'b1;
        end_status = st;
        end_len    = sat_sum(rec_start, extra);
    endfunction

    function automatic void push_word(input logic kind, input logic [31:0] val,
                                      input frbp_status_t st, input logic fin);
        frbp_out_t w;
        w.result_kind  = kind;
        w.offset_value = val[OUT_W-1:0];
        w.stop_status  = st;
        w.final_mark   = fin;
        expected_words.push_back(w);
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic last);
        logic [9:0] idx;
        if (!halted) begin
            idx = rec_bytes;
            if (idx == 0)
                rec_start = page_pos;
            page_pos = sat_sum(page_pos, 32'd1);
            if (rec_bytes < BIR_MAX)
                rec_bytes = rec_bytes + 10'd1;
            if (idx == 0) begin
                src_b = b;
                if (b == 8'h00)
                    halt_parse(ST_ZERO_SRC, 32'd1);
            end else if (idx == 1) begin
                flg_b = b;
                if ((src_b & SRC_BAD_MASK) != 0) begin
                    halt_parse(ST_BAD_SRC, 32'd2);
                end else if ((src_b & SRC_LIST) == 0) begin
                    if ((flg_b & FLG_TGT_MASK) != 0) begin
                        halt_parse(ST_BAD_TGT, 32'd4);
                    end else begin
                        need_len  = record_bytes(src_b, flg_b, 8'd1);
                        len_known = 1'b1;
                    end
                end
            end else if (idx == 2 && (src_b & SRC_LIST) != 0 && !len_known) begin
                if ((flg_b & FLG_TGT_MASK) != 0) begin
                    halt_parse(ST_BAD_TGT, 32'd3);
                end else begin
                    need_len  = record_bytes(src_b, flg_b, b);
                    len_known = 1'b1;
                end
            end
            if (!halted && len_known && rec_bytes == need_len) begin
                push_word(KIND_START, rec_start, ST_END, 1'b0);
                rec_bytes = '0;
                need_len  = '0;
                len_known = 1'b0;
            end
            if (last && !halted) begin
                if (rec_bytes == 0) begin
                    end_status = ST_END;
                    end_len    = page_pos;
                end else begin
                    end_status = ST_TRUNC;
                    end_len    = sat_sum(rec_start, len_known ? 32'(need_len) : 32'(rec_bytes));
                end
            end
        end
        if (last) begin
            push_word(KIND_FINAL, end_len, end_status, 1'b1);
            clear_parse_state();
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("ERROR @%0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_word(input frbp_out_t got);
        frbp_out_t want;
        if (expected_words.size() == 0) begin
            report_mismatch("unexpected word, offset", 32'(got.offset_value), 32'd0);
        end else begin
            want = expected_words.pop_front();
            if (got.result_kind !== want.result_kind)
                report_mismatch("result_kind", 32'(got.result_kind), 32'(want.result_kind));
            if (got.offset_value !== want.offset_value)
                report_mismatch("offset_value", 32'(got.offset_value),
                                32'(want.offset_value));
            if (got.stop_status !== want.stop_status)
                report_mismatch("stop_status", 32'(got.stop_status), 32'(want.stop_status));
            if (got.final_mark !== want.final_mark)
                report_mismatch("final_mark", 32'(got.final_mark), 32'(want.final_mark));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            check_word(m_data);
    end

    // receiver: random stalls plus counted hold-off
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !(receiver_gaps && $urandom_range(99) < 28);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge aclk);
        while (sender_gaps && $urandom_range(99) < 28) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{data_byte: b, last_byte: last};
        do @(posedge aclk); while (!s_ready);
        parse_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_bytes(input bit mark_last);
        foreach (page_bytes[i])
            send_byte(page_bytes[i], mark_last && i == page_bytes.size() - 1);
        page_bytes.delete();
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    function automatic logic [7:0] good_src(input bit list);
        logic [7:0] src;
        src = {2'b00, list, 5'($urandom_range(0, 31))};
        if (src == 8'h00)
            src = 8'h07;
        return src;
    endfunction

    function automatic logic [7:0] good_cnt();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return 8'($urandom_range(0, 6));
        else if (r < 97)
            return 8'($urandom_range(7, 40));
        return 8'($urandom_range(41, 255));
    endfunction

    // appends one well-formed record with random body, optionally cut short
    function automatic void add_record(input logic [7:0] src, input logic [7:0] flg,
                                       input logic [7:0] cnt, input bit cut);
        logic [9:0] len;
        int         keep;
        len = record_bytes(src, flg, cnt);
        keep = cut ? $urandom_range(1, len - 1) : len;
        for (int i = 0; i < keep; i++) begin
            if (i == 0)
                page_bytes.push_back(src);
            else if (i == 1)
                page_bytes.push_back(flg);
            else if (i == 2 && (src & SRC_LIST) != 0)
                page_bytes.push_back(cnt);
            else
                page_bytes.push_back(8'($urandom));
        end
    endfunction

    function automatic void add_random_record(input bit cut);
        logic [7:0] src;
        src = good_src($urandom_range(1));
        add_record(src, {6'($urandom), 2'b00}, good_cnt(), cut);
    endfunction

    function automatic void add_broken_record();
        logic [7:0] src;
        case ($urandom_range(3))
            0: page_bytes.push_back(8'h00);
            1: begin
                src = {2'($urandom_range(1, 3)), 6'($urandom)};
                page_bytes.push_back(src);
                page_bytes.push_back(8'($urandom));
            end
            2: begin
                page_bytes.push_back(good_src(1'b0));
                page_bytes.push_back({6'($urandom), 2'($urandom_range(1, 3))});
            end
            default: begin
                page_bytes.push_back(good_src(1'b1));
                page_bytes.push_back({6'($urandom), 2'($urandom_range(1, 3))});
                page_bytes.push_back(8'($urandom));
            end
        endcase
        repeat ($urandom_range(0, 5))
            page_bytes.push_back(8'($urandom));
    endfunction

    task automatic test_directed_cases();
        page_bytes = '{8'h00};
        send_bytes(1'b1);
        page_bytes = '{8'h02, 8'h00, 8'hA5, 8'h5A, 8'h3C};
        send_bytes(1'b1);
        page_bytes = '{8'h22, 8'h40, 8'h00, 8'h7E, 8'h81};
        send_bytes(1'b1);
        page_bytes = '{8'hC0, 8'h00, 8'hFF};
        send_bytes(1'b1);
        page_bytes = '{8'h07, 8'h01, 8'h55};
        send_bytes(1'b1);
        page_bytes = '{8'h27, 8'h02, 8'h05};
        send_bytes(1'b1);
        page_bytes = '{8'h07, 8'h10};
        send_bytes(1'b1);
        page_bytes = '{8'h27};
        send_bytes(1'b1);
        wait_drained();
    endtask

    task automatic test_random_pages();
        int start;
        int r;
        start = bytes_sent;
        while (bytes_sent - start < 850) begin
            sender_gaps   = (bytes_sent - start) >= 200;
            receiver_gaps = sender_gaps;
            r = $urandom_range(99);
            if (r < 65) begin
                repeat ($urandom_range(1, 4))
                    add_random_record(1'b0);
                if ($urandom_range(99) < 40)
                    add_random_record(1'b1);
            end else if (r < 88) begin
                repeat ($urandom_range(0, 2))
                    add_random_record(1'b0);
                add_broken_record();
            end else begin
                repeat ($urandom_range(1, 12))
                    page_bytes.push_back(8'($urandom));
            end
            send_bytes(1'b1);
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b1;
        hold_cycles   = 300;
        repeat (20)
            add_record(8'h22, 8'h00, 8'h00, 1'b0);
        send_bytes(1'b1);
        wait_drained();
        sender_gaps = 1'b1;
        repeat (6)
            add_random_record(1'b0);
        send_bytes(1'b1);
        wait_drained();
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        mismatch_count = 0;
        bytes_sent     = 0;
        hold_cycles    = 0;
        sender_gaps    = 1'b1;
        receiver_gaps  = 1'b1;
        clear_parse_state();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_random_pages();
        test_backpressure();

        if (mismatch_count == 0)
            $display("fixup_record_boundary_parser_unit: match");
        else
            $display("fixup_record_boundary_parser_unit: mismatch");
        $finish;
    end

endmodule
